[design/fbi_pkg.sv]
// Shared types and constants of the Filon bin integral unit.
// Holds fixed-point constants, the CORDIC arctangent table and payload structs.
// No dependencies.
`timescale 1ns / 1ps

package fbi_pkg;

	localparam int AMP_W       = 32;
	localparam int PH_W        = 48;
	localparam int WID_W       = 32;
	localparam int THR_W       = 25;
	localparam int RES_W       = 32;
	localparam int AD_W        = PH_W + 1;
	localparam int IN_TDATA_W  = AMP_W + 2 * PH_W + WID_W;
	localparam int OUT_TDATA_W = 2 * RES_W;
	localparam int OUT_TUSER_W = 2;
	localparam int CW          = 36;

	localparam logic [THR_W-1:0] THR_RESET = 25'd23170;

	localparam logic [63:0]          TWO_PI_Q32      = 64'd26986075409;
	localparam logic signed [CW-1:0] PI_Q30          = 36'sd3373259426;
	localparam logic signed [CW-1:0] TWO_PI_Q30      = 36'sd6746518852;
	localparam logic signed [CW-1:0] HALF_PI_Q30     = 36'sd1686629713;
	localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 36'sd652032874;

	localparam logic [AD_W-1:0]  TRAP_DIVISOR = 49'd65536;
	localparam logic [RES_W-1:0] SAT_POS      = 32'h7FFF_FFFF;
	localparam logic [RES_W-1:0] SAT_NEG      = 32'h8000_0000;

	// Per-bin values that ride along the pipeline.
	typedef struct packed {
		logic [AMP_W-1:0] am;
		logic             aneg;
		logic [WID_W-1:0] w;
		logic [AD_W-1:0]  ad;
		logic             dneg;
		logic             trap;
	} bin_t;

	typedef struct packed {
		logic             sat;
		logic             trap;
		logic [RES_W-1:0] im;
		logic [RES_W-1:0] re;
	} out_t;

	// atan(2^-i) in Q.30
	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] r;
		case (i)
			5'd0:    r = 30'd843314857;
			5'd1:    r = 30'd497837829;
			5'd2:    r = 30'd263043837;
			5'd3:    r = 30'd133525159;
			5'd4:    r = 30'd67021687;
			5'd5:    r = 30'd33543516;
			5'd6:    r = 30'd16775851;
			5'd7:    r = 30'd8388437;
			5'd8:    r = 30'd4194283;
			5'd9:    r = 30'd2097149;
			5'd31:   r = 30'd0;
			default: r = 30'd1 << (5'd30 - i);
		endcase
		return r;
	endfunction

endpackage

[design/filon_bin_integral_unit.sv]
// Filon bin integral unit: top level, the whole pipelined datapath.
// Phase reduction, two CORDIC lanes, width/amplitude scaling, two dividers.
// Depends on fbi_pkg.
`timescale 1ns / 1ps

// Usage:
//  s_axis carries one bin per item (amplitude, phase_left, phase_right,
//  bin_width); m_axis returns one item per bin with the saturated Q16.16
//  real and imaginary parts and two flags in tuser.
//  cfg_wr_en/cfg_wr_data load the small-phase threshold; write it only
//  while no item is in flight.
//  Throughput: one item per cycle, sustained while m_axis is not stalled.
//  Pipeline: one compare/subtract stage per phase-reduction step, one
//  stage per CORDIC rotation and one stage per quotient bit (32) of the
//  dividers, with the scaling stages between the CORDIC and the dividers.
//  Reset: all stages empty, threshold back to 23170.
//  Stall: the output register plus a one-entry skid take the last item;
//  s_axis_tready drops only once the skid holds an item, and the whole
//  pipeline then freezes until the receiver takes one.
module filon_bin_integral_unit #(
	parameter int CORDIC_STAGES   = 24,
	parameter int PHASE_FRAC_BITS = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// amplitude, phase_left, phase_right, bin_width
	input  logic [fbi_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// result_real, result_imag
	output logic [fbi_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// used_trapezoid, saturated
	output logic [fbi_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
	input  logic                             cfg_wr_en,
	input  logic [fbi_pkg::THR_W-1:0]        cfg_wr_data
);
	import fbi_pkg::*;

	localparam int F      = PHASE_FRAC_BITS;
	localparam int CS     = CORDIC_STAGES;
	localparam logic [63:0] TWO_PI_F = (TWO_PI_Q32 + (64'd1 << (31 - F))) >> (32 - F);
	localparam int KR     = 48 - F;
	localparam int RW     = 52;
	localparam int AS     = 30 - F;
	localparam int PSH    = F - 16;
	localparam int NUM_W  = 68 + PSH;
	localparam int REM_W  = ((NUM_W > 81) ? NUM_W : 81) + 1;
	localparam int QW     = 32;

	logic ce;
	logic [THR_W-1:0] thr_q;

	// ---------------- input decode ----------------
	logic [AMP_W-1:0] in_amp;
	logic [PH_W-1:0]  in_pl, in_pr;
	logic [WID_W-1:0] in_w;
	logic [AD_W-1:0]  in_d;
	bin_t             bin_in;
	logic [PH_W-1:0]  in_ml, in_mr;

	always_comb begin
		in_amp = s_axis_tdata[AMP_W-1:0];
		in_pl  = s_axis_tdata[AMP_W+PH_W-1:AMP_W];
		in_pr  = s_axis_tdata[AMP_W+2*PH_W-1:AMP_W+PH_W];
		in_w   = s_axis_tdata[IN_TDATA_W-1:AMP_W+2*PH_W];
		in_d   = {in_pr[PH_W-1], in_pr} - {in_pl[PH_W-1], in_pl};
		bin_in.aneg = in_amp[AMP_W-1];
		bin_in.am   = in_amp[AMP_W-1] ? -in_amp : in_amp;
		bin_in.w    = in_w;
		bin_in.dneg = in_d[AD_W-1];
		bin_in.ad   = in_d[AD_W-1] ? -in_d : in_d;
		// zero difference always takes the trapezoid path
		bin_in.trap = (in_d == '0) || (bin_in.ad < AD_W'(thr_q));
		in_ml = in_pl[PH_W-1] ? -in_pl : in_pl;
		in_mr = in_pr[PH_W-1] ? -in_pr : in_pr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	// ---------------- phase reduction: |phase| mod 2*pi ----------------
	logic          red_v_s [0:KR];
	bin_t          red_b_s [0:KR];
	logic [RW-1:0] red_m_s [2][0:KR];
	logic          red_n_s [2][0:KR];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_v_s[0] <= 1'b0;
		end else if (ce) begin
			red_v_s[0] <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			red_b_s[0]    <= bin_in;
			red_m_s[0][0] <= RW'(in_ml);
			red_m_s[1][0] <= RW'(in_mr);
			red_n_s[0][0] <= in_pl[PH_W-1];
			red_n_s[1][0] <= in_pr[PH_W-1];
		end
	end

	for (genvar j = 0; j < KR; j++) begin : g_red
		localparam logic [RW-1:0] CK = RW'(TWO_PI_F) << (KR - 1 - j);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				red_v_s[j+1] <= 1'b0;
			end else if (ce) begin
				red_v_s[j+1] <= red_v_s[j];
			end
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				red_b_s[j+1] <= red_b_s[j];
				for (int ln = 0; ln < 2; ln++) begin
					red_m_s[ln][j+1] <= (red_m_s[ln][j] >= CK) ? red_m_s[ln][j] - CK
										: red_m_s[ln][j];
					red_n_s[ln][j+1] <= red_n_s[ln][j];
				end
			end
		end
	end

	// negative phase: floor modulo
	logic          fa_v_s;
	bin_t          fa_b_s;
	logic [RW-1:0] fa_m_s [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fa_v_s <= 1'b0;
		end else if (ce) begin
			fa_v_s <= red_v_s[KR];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			fa_b_s <= red_b_s[KR];
			for (int ln = 0; ln < 2; ln++) begin
				fa_m_s[ln] <= (red_n_s[ln][KR] && red_m_s[ln][KR] != '0)
					? RW'(TWO_PI_F) - red_m_s[ln][KR] : red_m_s[ln][KR];
			end
		end
	end

	// to Q.30 and fold into [-pi/2, pi/2]; msb of result is the flip
	function automatic logic [CW:0] fold_q30(input logic [RW-1:0] rr);
		logic signed [CW-1:0] a;
		logic                 fl;
		a  = signed'(CW'(rr) << AS);
		fl = 1'b0;
		if (a > PI_Q30) a = a - TWO_PI_Q30;
		if (a > HALF_PI_Q30) begin
			a  = a - PI_Q30;
			fl = 1'b1;
		end else if (a < -HALF_PI_Q30) begin
			a  = a + PI_Q30;
			fl = 1'b1;
		end
		return {fl, a};
	endfunction

	// ---------------- CORDIC, rotation mode ----------------
	logic                 cv_s  [0:CS];
	bin_t                 cb_s  [0:CS];
	logic signed [CW-1:0] cx_s  [2][0:CS];
	logic signed [CW-1:0] cy_s  [2][0:CS];
	logic signed [CW-1:0] cz_s  [2][0:CS];
	logic                 cfl_s [2][0:CS];
	logic [CW:0]          fold_r [2];

	always_comb begin
		for (int ln = 0; ln < 2; ln++) begin
			fold_r[ln] = fold_q30(fa_m_s[ln]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_s[0] <= 1'b0;
		end else if (ce) begin
			cv_s[0] <= fa_v_s;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			cb_s[0] <= fa_b_s;
			for (int ln = 0; ln < 2; ln++) begin
				cx_s[ln][0]  <= CORDIC_GAIN_Q30;
				cy_s[ln][0]  <= '0;
				cz_s[ln][0]  <= signed'(fold_r[ln][CW-1:0]);
				cfl_s[ln][0] <= fold_r[ln][CW];
			end
		end
	end

	for (genvar i = 0; i < CS; i++) begin : g_cordic
		localparam logic signed [CW-1:0] AT = CW'(atan_q30(5'(i)));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[i+1] <= 1'b0;
			end else if (ce) begin
				cv_s[i+1] <= cv_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				cb_s[i+1] <= cb_s[i];
				for (int ln = 0; ln < 2; ln++) begin
					cfl_s[ln][i+1] <= cfl_s[ln][i];
					if (cz_s[ln][i] >= 0) begin
						cx_s[ln][i+1] <= cx_s[ln][i] - (cy_s[ln][i] >>> i);
						cy_s[ln][i+1] <= cy_s[ln][i] + (cx_s[ln][i] >>> i);
						cz_s[ln][i+1] <= cz_s[ln][i] - AT;
					end else begin
						cx_s[ln][i+1] <= cx_s[ln][i] + (cy_s[ln][i] >>> i);
						cy_s[ln][i+1] <= cy_s[ln][i] - (cx_s[ln][i] >>> i);
						cz_s[ln][i+1] <= cz_s[ln][i] + AT;
					end
				end
			end
		end
	end

	// ---------------- scaling tail ----------------
	// lane 0 = real part, lane 1 = imaginary part
	logic                 v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	bin_t                 b_s1, b_s2, b_s3, b_s4, b_s5, b_s6;
	logic signed [CW-1:0] ux_s1 [2];
	logic signed [CW-1:0] uy_s1 [2];
	logic [32:0]          cm_s2 [2];
	logic                 cn_s2 [2];
	logic [64:0]          prod_s3 [2];
	logic                 cn_s3 [2];
	logic [35:0]          vm_s4 [2];
	logic                 vn_s4 [2];
	logic [63:0]          lo_s5 [2];
	logic [35:0]          hi_s5 [2];
	logic                 vn_s5 [2];
	logic [NUM_W-1:0]     num_s6 [2];
	logic                 neg_s6 [2];
	logic [AD_W-1:0]      dv_s6;

	logic signed [CW:0]   comp [2];
	logic signed [CW:0]   cmag [2];
	logic [65:0]          rsum [2];
	logic [67:0]          p68  [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (ce) begin
			v_s1 <= cv_s[CS];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_comb begin
		// trapezoid: sum of vectors; Filon: -i * (right - left)
		comp[0] = b_s1.trap ? (CW+1)'(ux_s1[0]) + (CW+1)'(ux_s1[1])
							: (CW+1)'(uy_s1[1]) - (CW+1)'(uy_s1[0]);
		comp[1] = b_s1.trap ? (CW+1)'(uy_s1[0]) + (CW+1)'(uy_s1[1])
							: (CW+1)'(ux_s1[1]) - (CW+1)'(ux_s1[0]);
		for (int ln = 0; ln < 2; ln++) begin
			cmag[ln] = comp[ln][CW] ? -comp[ln] : comp[ln];
			rsum[ln] = b_s3.trap ? (66'(prod_s3[ln]) + (66'd1 << 30)) >> 31
								 : (66'(prod_s3[ln]) + (66'd1 << 29)) >> 30;
			p68[ln]  = {hi_s5[ln], 32'd0} + 68'(lo_s5[ln]);
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			b_s1 <= cb_s[CS];
			b_s2 <= b_s1;
			b_s3 <= b_s2;
			b_s4 <= b_s3;
			b_s5 <= b_s4;
			b_s6 <= b_s5;
			dv_s6 <= b_s5.trap ? TRAP_DIVISOR : b_s5.ad;
			for (int ln = 0; ln < 2; ln++) begin
				ux_s1[ln]   <= cfl_s[ln][CS] ? -cx_s[ln][CS] : cx_s[ln][CS];
				uy_s1[ln]   <= cfl_s[ln][CS] ? -cy_s[ln][CS] : cy_s[ln][CS];
				cm_s2[ln]   <= cmag[ln][32:0];
				cn_s2[ln]   <= comp[ln][CW];
				prod_s3[ln] <= 65'(cm_s2[ln]) * 65'(b_s2.w);
				cn_s3[ln]   <= cn_s2[ln];
				vm_s4[ln]   <= rsum[ln][35:0];
				vn_s4[ln]   <= cn_s3[ln];
				lo_s5[ln]   <= 64'(vm_s4[ln][31:0]) * 64'(b_s4.am);
				hi_s5[ln]   <= 36'(vm_s4[ln][35:32]) * 36'(b_s4.am);
				vn_s5[ln]   <= vn_s4[ln];
				num_s6[ln]  <= b_s5.trap ? NUM_W'(p68[ln]) : NUM_W'(p68[ln]) << PSH;
			end
			neg_s6[0] <= vn_s5[0] ^ b_s5.aneg ^ (!b_s5.trap && b_s5.dneg);
			neg_s6[1] <= vn_s5[1] ^ b_s5.aneg ^ (!b_s5.trap && !b_s5.dneg);
		end
	end

	// ---------------- restoring dividers, one quotient bit per stage ----------------
	logic             dvl_s  [0:QW];
	bin_t             db_s   [0:QW];
	logic [AD_W-1:0]  ddv_s  [0:QW];
	logic [REM_W-1:0] dr_s   [2][0:QW];
	logic [QW-1:0]    dq_s   [2][0:QW];
	logic             dovf_s [2][0:QW];
	logic             dn_s   [2][0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvl_s[0] <= 1'b0;
		end else if (ce) begin
			dvl_s[0] <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			db_s[0]  <= b_s6;
			ddv_s[0] <= dv_s6;
			for (int ln = 0; ln < 2; ln++) begin
				dr_s[ln][0]   <= REM_W'(num_s6[ln]);
				dq_s[ln][0]   <= '0;
				// quotient of 2^32 or more always clamps
				dovf_s[ln][0] <= REM_W'(num_s6[ln]) >= (REM_W'(dv_s6) << QW);
				dn_s[ln][0]   <= neg_s6[ln];
			end
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int K = QW - 1 - j;
		logic [REM_W-1:0] ck;
		assign ck = REM_W'(ddv_s[j]) << K;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvl_s[j+1] <= 1'b0;
			end else if (ce) begin
				dvl_s[j+1] <= dvl_s[j];
			end
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				db_s[j+1]  <= db_s[j];
				ddv_s[j+1] <= ddv_s[j];
				for (int ln = 0; ln < 2; ln++) begin
					dovf_s[ln][j+1] <= dovf_s[ln][j];
					dn_s[ln][j+1]   <= dn_s[ln][j];
					if (dr_s[ln][j] >= ck) begin
						dr_s[ln][j+1] <= dr_s[ln][j] - ck;
						dq_s[ln][j+1] <= dq_s[ln][j] | (QW'(1) << K);
					end else begin
						dr_s[ln][j+1] <= dr_s[ln][j];
						dq_s[ln][j+1] <= dq_s[ln][j];
					end
				end
			end
		end
	end

	// round half away, sign, clamp
	logic [32:0]      q33 [2];
	logic             rnd [2];
	logic             psat [2];
	logic [RES_W-1:0] pval [2];
	out_t             fin;

	always_comb begin
		for (int ln = 0; ln < 2; ln++) begin
			rnd[ln]  = (REM_W+1)'({dr_s[ln][QW], 1'b0}) >= (REM_W+1)'(ddv_s[QW]);
			q33[ln]  = 33'(dq_s[ln][QW]) + 33'(rnd[ln]);
			psat[ln] = dovf_s[ln][QW] || (dn_s[ln][QW] ? (q33[ln] > 33'(SAT_NEG))
													 : (q33[ln] > 33'(SAT_POS)));
			if (psat[ln]) begin
				pval[ln] = dn_s[ln][QW] ? SAT_NEG : SAT_POS;
			end else begin
				pval[ln] = dn_s[ln][QW] ? RES_W'(-q33[ln]) : q33[ln][RES_W-1:0];
			end
		end
		fin.re   = pval[0];
		fin.im   = pval[1];
		fin.trap = db_s[QW].trap;
		fin.sat  = psat[0] || psat[1];
	end

	// ---------------- output register and skid ----------------
	logic o_v_q, sk_v_q;
	out_t o_d_q, sk_d_q;

	assign ce            = !sk_v_q;
	assign s_axis_tready = ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q  <= 1'b0;
			sk_v_q <= 1'b0;
		end else if (!o_v_q || m_axis_tready) begin
			if (sk_v_q) begin
				o_v_q  <= 1'b1;
				sk_v_q <= 1'b0;
			end else begin
				o_v_q <= dvl_s[QW];
			end
		end else if (dvl_s[QW] && ce) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!o_v_q || m_axis_tready) begin
			o_d_q <= sk_v_q ? sk_d_q : fin;
		end else if (ce) begin
			sk_d_q <= fin;
		end
	end

	assign m_axis_tvalid = o_v_q;
	assign m_axis_tdata  = {o_d_q.im, o_d_q.re};
	assign m_axis_tuser  = {o_d_q.sat, o_d_q.trap};

	// ---------------- assertions ----------------
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> o_v_q)
		else $error("skid holds an item while the output register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_v_q) |-> $past(o_v_q && !m_axis_tready))
		else $error("skid filled without an output stall");

	a_sat_clamps: assert property (@(posedge clk) disable iff (!arst_n)
		(o_v_q && o_d_q.sat) |-> (o_d_q.re == SAT_POS || o_d_q.re == SAT_NEG ||
			o_d_q.im == SAT_POS || o_d_q.im == SAT_NEG))
		else $error("saturated flag without a clamped part");

endmodule
